[src/mpfw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfw_pkg
// Shared types and constants of the page-organized monochrome framebuffer writer.
// ----------------------------------------------------------------------------
package mpfw_pkg;

	localparam int MAX_WIDTH_DEF  = 128;
	localparam int MAX_HEIGHT_DEF = 64;

	localparam int OP_W       = 3;
	localparam int X_W        = 7;
	localparam int Y_W        = 6;
	localparam int WS_W       = 8;
	localparam int HS_W       = 7;
	localparam int COUNT_W    = 16;
	localparam int ADDR_W     = 10;
	localparam int BYTE_W     = 8;
	localparam int UPD_W      = 32;
	localparam int CFG_W_W    = 8;
	localparam int CFG_H_W    = 7;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_W_W-1:0] CFG_W_RST = 8'd128;
	localparam logic [CFG_H_W-1:0] CFG_H_RST = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_SET_WIN   = 3'd0,
		OP_SET_START = 3'd1,
		OP_FILL_RUN  = 3'd2,
		OP_DRAW_PIX  = 3'd3,
		OP_FILL_RECT = 3'd4,
		OP_READ_BYTE = 3'd5
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_WR,
		ST_FINISH
	} state_t;

	// First member in the highest bits: fields run from address down to x.
	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [COUNT_W-1:0] count;
		logic               color;
		logic [HS_W-1:0]    h;
		logic [WS_W-1:0]    w;
		logic [Y_W-1:0]     y;
		logic [X_W-1:0]     x;
	} in_fields_t;

	localparam int IN_BITS    = $bits(in_fields_t);
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [UPD_W-1:0]  update_count;
		logic [BYTE_W-1:0] read_data;
	} out_data_t;

	localparam int OUT_DATA_W = $bits(out_data_t);

	typedef struct packed {
		logic take_in;
		logic set_win;
		logic set_start;
		logic bump;
		logic rect_init;
		logic rd_pix;
		logic rd_byte;
		logic wr;
		logic step_run;
		logic step_rect;
		logic clear;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic count_zero;
		logic tgt_ok;
		logic rect_abort;
		logic rect_empty;
		logic rect_last;
		logic clr_last;
		logic out_free;
	} stat_t;

endpackage

[src/mpfw_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mpfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/mpfw_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfw_ctrl
// Operation sequencer: store clearing, item decode, read-modify-write steps.
// ----------------------------------------------------------------------------
module mpfw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  mpfw_pkg::stat_t stat,
	output mpfw_pkg::cmd_t  cmd
);

	mpfw_pkg::state_t state_q;
	mpfw_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mpfw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			mpfw_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = mpfw_pkg::ST_IDLE;
				end
			end
			mpfw_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take_in = 1'b1;
					state_d     = mpfw_pkg::ST_EXEC;
				end
			end
			mpfw_pkg::ST_EXEC: begin
				state_d = mpfw_pkg::ST_FINISH;
				unique case (stat.op)
					mpfw_pkg::OP_SET_WIN:   cmd.set_win = 1'b1;
					mpfw_pkg::OP_SET_START: cmd.set_start = 1'b1;
					mpfw_pkg::OP_FILL_RUN: begin
						cmd.bump = 1'b1;
						state_d  = mpfw_pkg::ST_RD;
					end
					mpfw_pkg::OP_DRAW_PIX: begin
						if (stat.tgt_ok) begin
							cmd.bump = 1'b1;
							state_d  = mpfw_pkg::ST_RD;
						end
					end
					mpfw_pkg::OP_FILL_RECT: begin
						if (!stat.rect_abort) begin
							cmd.bump = 1'b1;
							if (!stat.rect_empty) begin
								cmd.rect_init = 1'b1;
								state_d       = mpfw_pkg::ST_RD;
							end
						end
					end
					mpfw_pkg::OP_READ_BYTE: cmd.rd_byte = 1'b1;
					default: ;
				endcase
			end
			mpfw_pkg::ST_RD: begin
				if (stat.op == mpfw_pkg::OP_FILL_RUN && stat.count_zero) begin
					state_d = mpfw_pkg::ST_FINISH;
				end else if (stat.tgt_ok) begin
					cmd.rd_pix = 1'b1;
					state_d    = mpfw_pkg::ST_WR;
				end else begin
					cmd.step_run = 1'b1;
				end
			end
			mpfw_pkg::ST_WR: begin
				cmd.wr  = 1'b1;
				state_d = mpfw_pkg::ST_FINISH;
				if (stat.op == mpfw_pkg::OP_FILL_RUN) begin
					cmd.step_run = 1'b1;
					state_d      = mpfw_pkg::ST_RD;
				end else if (stat.op == mpfw_pkg::OP_FILL_RECT) begin
					cmd.step_rect = 1'b1;
					if (!stat.rect_last) begin
						state_d = mpfw_pkg::ST_RD;
					end
				end
			end
			mpfw_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = mpfw_pkg::ST_IDLE;
				end
			end
			default: state_d = mpfw_pkg::ST_CLEAR;
		endcase
	end

endmodule

[src/mpfw_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfw_dp
// Datapath: configuration, window and cursor, rectangle walker, pixel
// addressing, byte store and result register.
// ----------------------------------------------------------------------------
module mpfw_dp #(
	parameter int MAX_WIDTH  = mpfw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mpfw_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mpfw_pkg::cmd_t                      cmd,
	output mpfw_pkg::stat_t                     stat,
	input  logic [mpfw_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic [mpfw_pkg::OP_W-1:0]           s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mpfw_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpfw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpfw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PAGES = (MAX_HEIGHT + 7) / 8;
	localparam int DEPTH = MAX_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = ($clog2(MAX_WIDTH) > mpfw_pkg::X_W) ?
	                       $clog2(MAX_WIDTH) : mpfw_pkg::X_W;
	localparam int YW    = ($clog2(MAX_HEIGHT) > mpfw_pkg::Y_W) ?
	                       $clog2(MAX_HEIGHT) : mpfw_pkg::Y_W;
	localparam int PGW   = YW - 3;
	localparam int IW    = mpfw_pkg::CFG_W_W + PGW + 1;

	mpfw_pkg::in_fields_t in_d;
	assign in_d = mpfw_pkg::in_fields_t'(s_tdata[mpfw_pkg::IN_BITS-1:0]);

	// configuration
	logic [mpfw_pkg::CFG_W_W-1:0] width_q;
	logic [mpfw_pkg::CFG_H_W-1:0] height_q;
	logic [mpfw_pkg::CFG_W_W-1:0] wd;
	logic [mpfw_pkg::CFG_H_W-1:0] ht;

	// latched item
	mpfw_pkg::op_t                op_q;
	logic [mpfw_pkg::X_W-1:0]     x_q;
	logic [mpfw_pkg::Y_W-1:0]     y_q;
	logic [mpfw_pkg::WS_W-1:0]    w_q;
	logic [mpfw_pkg::HS_W-1:0]    h_q;
	logic                         color_q;
	logic [mpfw_pkg::COUNT_W-1:0] count_q;
	logic [mpfw_pkg::ADDR_W-1:0]  address_q;

	// window, cursor, counter
	logic [mpfw_pkg::X_W-1:0]   win_xs_q;
	logic [mpfw_pkg::Y_W-1:0]   win_ys_q;
	logic [XW-1:0]              win_xe_q;
	logic [YW-1:0]              win_ye_q;
	logic [XW-1:0]              cur_x_q;
	logic [YW-1:0]              cur_y_q;
	logic [mpfw_pkg::UPD_W-1:0] upd_q;

	// rectangle walker
	logic [XW-1:0]                lx_q;
	logic [PGW-1:0]               page_q;
	logic [mpfw_pkg::CFG_W_W-1:0] endx_q;
	logic [mpfw_pkg::CFG_H_W-1:0] endy_q;

	// store access
	logic [AW-1:0]                 wr_addr_q;
	logic [mpfw_pkg::BYTE_W-1:0]   wr_mask_q;
	logic [AW-1:0]                 clr_addr_q;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [mpfw_pkg::BYTE_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [mpfw_pkg::BYTE_W-1:0]   ram_rdata;
	logic                          addr_ok;

	// result register
	logic                 m_tvalid_q;
	mpfw_pkg::out_data_t  m_data_q;

	// pixel target
	logic [XW-1:0]               px;
	logic [YW-1:0]               py;
	logic                        pt_ok;
	logic                        is_rect;
	logic [XW-1:0]               tgt_px;
	logic [PGW-1:0]              tgt_pg;
	logic [mpfw_pkg::BYTE_W-1:0] tgt_mask;
	logic                        tgt_ok;
	logic [IW-1:0]               idx_full;
	logic [AW-1:0]               tgt_idx;

	// rectangle set-up and masks
	logic [8:0]                   rx_end;
	logic [7:0]                   ry_end;
	logic                         rect_abort;
	logic [mpfw_pkg::CFG_W_W-1:0] endx_c;
	logic [mpfw_pkg::CFG_H_W-1:0] endy_c;
	logic                         rect_empty;
	logic [PGW-1:0]               first_pg;
	logic [mpfw_pkg::CFG_H_W-1:0] ey_m1;
	logic [PGW-1:0]               last_pg;
	logic [2:0]                   lo_bit;
	logic [2:0]                   hi_bit;
	logic [mpfw_pkg::BYTE_W-1:0]  rect_mask;
	logic                         lx_wrap;

	// window end clamp
	logic [mpfw_pkg::WS_W-1:0] sx;
	logic [mpfw_pkg::HS_W-1:0] sy;
	logic [8:0]                exw;
	logic [7:0]                eyw;
	logic [XW-1:0]             xe_c;
	logic [YW-1:0]             ye_c;

	// cursor step
	logic [8:0] nx;
	logic [8:0] ny;
	logic       wrap_x;
	logic       wrap_y;

	assign wd = ({1'b0, width_q} > 9'(MAX_WIDTH)) ? mpfw_pkg::CFG_W_W'(MAX_WIDTH) : width_q;
	assign ht = ({2'b0, height_q} > 9'(MAX_HEIGHT)) ? mpfw_pkg::CFG_H_W'(MAX_HEIGHT) : height_q;

	assign is_rect = (op_q == mpfw_pkg::OP_FILL_RECT);

	always_comb begin
		if (op_q == mpfw_pkg::OP_FILL_RUN) begin
			px = cur_x_q;
			py = cur_y_q;
		end else begin
			px = XW'(x_q);
			py = YW'(y_q);
		end
	end

	assign pt_ok    = (9'(px) < 9'(wd)) && (9'(py) < 9'(ht));
	assign tgt_px   = is_rect ? lx_q : px;
	assign tgt_pg   = is_rect ? page_q : PGW'(py >> 3);
	assign tgt_mask = is_rect ? rect_mask : (8'd1 << py[2:0]);
	assign tgt_ok   = is_rect | pt_ok;
	assign idx_full = IW'(wd) * IW'(tgt_pg) + IW'(tgt_px);
	assign tgt_idx  = idx_full[AW-1:0];

	assign rx_end     = 9'(x_q) + 9'(w_q);
	assign ry_end     = 8'(y_q) + 8'(h_q);
	assign rect_abort = ((rx_end > 9'(wd)) && (9'(x_q) > 9'(wd))) ||
	                    ((ry_end > 8'(ht)) && (8'(y_q) > 8'(ht)));
	assign endx_c     = (rx_end > 9'(wd)) ? wd : rx_end[7:0];
	assign endy_c     = (ry_end > 8'(ht)) ? ht : ry_end[6:0];
	assign rect_empty = (9'(x_q) >= 9'(endx_c)) || (8'(y_q) >= 8'(endy_c));

	assign first_pg  = PGW'(y_q >> 3);
	assign ey_m1     = endy_q - 7'd1;
	assign last_pg   = PGW'(ey_m1 >> 3);
	assign lo_bit    = (page_q == first_pg) ? y_q[2:0] : 3'd0;
	assign hi_bit    = (page_q == last_pg) ? ey_m1[2:0] : 3'd7;
	assign rect_mask = (8'hFF << lo_bit) & (8'hFF >> (3'd7 - hi_bit));
	assign lx_wrap   = (9'(lx_q) + 9'd1) >= 9'(endx_q);

	assign sx   = (w_q == '0) ? 8'd1 : w_q;
	assign sy   = (h_q == '0) ? 7'd1 : h_q;
	assign exw  = 9'(x_q) + 9'(sx) - 9'd1;
	assign eyw  = 8'(y_q) + 8'(sy) - 8'd1;
	assign xe_c = (wd == '0) ? '0 :
	              (exw > (9'(wd) - 9'd1)) ? XW'(wd - 8'd1) : XW'(exw);
	assign ye_c = (ht == '0) ? '0 :
	              (eyw > (8'(ht) - 8'd1)) ? YW'(ht - 7'd1) : YW'(eyw);

	assign nx     = 9'(cur_x_q) + 9'd1;
	assign ny     = 9'(cur_y_q) + 9'd1;
	assign wrap_x = nx > 9'(win_xe_q);
	assign wrap_y = ny > 9'(win_ye_q);

	assign addr_ok   = 32'(address_q) < 32'(DEPTH);
	assign ram_we    = cmd.clear | cmd.wr;
	assign ram_waddr = cmd.clear ? clr_addr_q : wr_addr_q;
	assign ram_wdata = cmd.clear ? '0 :
	                   (color_q ? (ram_rdata | wr_mask_q) : (ram_rdata & ~wr_mask_q));
	assign ram_re    = cmd.rd_pix | cmd.rd_byte;
	assign ram_raddr = cmd.rd_byte ? AW'(address_q) : tgt_idx;

	mpfw_ram #(
		.WIDTH (mpfw_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= mpfw_pkg::CFG_W_RST;
			height_q   <= mpfw_pkg::CFG_H_RST;
			win_xs_q   <= '0;
			win_ys_q   <= '0;
			win_xe_q   <= '0;
			win_ye_q   <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			upd_q      <= '0;
			clr_addr_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (mpfw_pkg::cfg_idx_t'(cfg_index))
					mpfw_pkg::CFG_WIDTH:  width_q <= cfg_data;
					mpfw_pkg::CFG_HEIGHT: height_q <= cfg_data[mpfw_pkg::CFG_H_W-1:0];
					default: ;
				endcase
			end
			if (cmd.set_win) begin
				win_xe_q <= xe_c;
				win_ye_q <= ye_c;
			end
			if (cmd.set_win | cmd.set_start) begin
				win_xs_q <= x_q;
				win_ys_q <= y_q;
				cur_x_q  <= XW'(x_q);
				cur_y_q  <= YW'(y_q);
			end
			if (cmd.step_run) begin
				if (wrap_x) begin
					cur_x_q <= XW'(win_xs_q);
					cur_y_q <= wrap_y ? YW'(win_ys_q) : YW'(ny);
				end else begin
					cur_x_q <= XW'(nx);
				end
			end
			if (cmd.bump) begin
				upd_q <= upd_q + 32'd1;
			end
			if (cmd.clear) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q      <= mpfw_pkg::op_t'(s_tuser);
			x_q       <= in_d.x;
			y_q       <= in_d.y;
			w_q       <= in_d.w;
			h_q       <= in_d.h;
			color_q   <= in_d.color;
			address_q <= in_d.address;
		end
		if (cmd.take_in) begin
			count_q <= in_d.count;
		end else if (cmd.step_run) begin
			count_q <= count_q - 16'd1;
		end
		if (cmd.rect_init) begin
			lx_q   <= XW'(x_q);
			page_q <= first_pg;
			endx_q <= endx_c;
			endy_q <= endy_c;
		end else if (cmd.step_rect) begin
			if (lx_wrap) begin
				lx_q   <= XW'(x_q);
				page_q <= page_q + 1'b1;
			end else begin
				lx_q <= lx_q + 1'b1;
			end
		end
		if (cmd.rd_pix) begin
			wr_addr_q <= tgt_idx;
			wr_mask_q <= tgt_mask;
		end
		if (cmd.load_out) begin
			m_data_q.read_data    <= (op_q == mpfw_pkg::OP_READ_BYTE && addr_ok) ?
			                         ram_rdata : '0;
			m_data_q.update_count <= upd_q;
		end
	end

	assign stat.op         = op_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.tgt_ok     = tgt_ok;
	assign stat.rect_abort = rect_abort;
	assign stat.rect_empty = rect_empty;
	assign stat.rect_last  = lx_wrap && (page_q == last_pg);
	assign stat.clr_last   = (clr_addr_q == AW'(DEPTH - 1));
	assign stat.out_free   = !m_tvalid_q || m_tready;

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign cfg_ready = 1'b1;

endmodule

[src/mono_page_framebuffer_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_page_framebuffer_writer
// Page-organized 1-bit framebuffer with window fill, pixel, rectangle and
// byte read-back operations.
// ----------------------------------------------------------------------------
// After reset the block zeroes all MAX_WIDTH*ceil(MAX_HEIGHT/8) bytes of the
// byte store (1024 at the defaults), with s_tready low; configuration writes
// are taken at any time. Every item gives one result. Window set-up, byte
// read-back and items that draw nothing go from decode straight to the
// result; a drawn pixel makes one read and one write; a fill run reads and
// writes each pixel inside the display and steps past those outside it; a
// rectangle reads and writes each byte column it touches in each page. All
// drawing goes through the single read-modify-write path into the byte
// store (one read, then one write, per byte). An item whose result is ready
// holds in its last state for as long as the previous result still waits at
// the output.
module mono_page_framebuffer_writer #(
	parameter int MAX_WIDTH  = mpfw_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = mpfw_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// x, y, w, h, color, count, address, one zero pad bit
	input  logic [mpfw_pkg::IN_DATA_W-1:0]      s_tdata,
	// opcode
	input  logic [mpfw_pkg::OP_W-1:0]           s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// read_data, update_count
	output logic [mpfw_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mpfw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mpfw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	mpfw_pkg::cmd_t  cmd;
	mpfw_pkg::stat_t stat;

	mpfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	mpfw_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

[src/mpfw_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfw_checker
// Port-level checks of the framebuffer writer, bound to its top level.
// ----------------------------------------------------------------------------
module mpfw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [mpfw_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic [1:0]                 pend_q;
	logic [mpfw_pkg::UPD_W-1:0] last_upd_q;
	logic                       have_q;
	logic                       s_acc;
	logic                       m_acc;
	mpfw_pkg::out_data_t        out_d;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;
	assign out_d = mpfw_pkg::out_data_t'(m_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= '0;
			last_upd_q <= '0;
			have_q     <= 1'b0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
			if (m_acc) begin
				last_upd_q <= out_d.update_count;
				have_q     <= 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc |-> pend_q != 2'd0)
		else $error("result without an accepted item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items in flight");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("item accepted in back-to-back cycles");

	a_upd_step: assert property (@(posedge clk) disable iff (!arst_n)
		m_acc && have_q |-> (out_d.update_count == last_upd_q) ||
		(out_d.update_count == last_upd_q + 32'd1))
		else $error("update count moved by more than one");

endmodule

bind mono_page_framebuffer_writer mpfw_checker u_mpfw_checker (.*);
